// ===== rtl/core/utf8_to_cp437_converter_top_macros.svh =====
// Assertion macros for the UTF-8 to CP437 converter.
`ifndef UTF8_TO_CP437_CONVERTER_TOP_MACROS_SVH
`define UTF8_TO_CP437_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define U2C_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define U2C_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U2C_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define U2C_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/u2c437_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u2c437_pkg
// Shared types and the CP437 multi-byte key table.
// ---------------------------------------------------------------------------
package u2c437_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned KeyW  = 24;

    typedef logic [KeyW-1:0] key_t;

    // Multi-byte UTF-8 key for each CP437 code, zero where none exists.
    localparam key_t MB_KEYS [256] = '{
        24'h0, 24'hE298BA, 24'hE298BB, 24'hE299A5, 24'hE299A6, 24'hE299A3, 24'hE299A0,
        24'hE280A2, 24'hE29798, 24'h0, 24'h0, 24'hE29982, 24'hE29980, 24'h0, 24'hE299AB,
        24'hE298BC,
        24'hE296BA, 24'hE29784, 24'hE28695, 24'hE280BC, 24'hC2B6, 24'hC2A7, 24'hE296AC,
        24'hE286A8, 24'hE28691, 24'hE28693, 24'hE28692, 24'hE28690, 24'hE2889F,
        24'hE28694, 24'hE296B2, 24'hE296BC,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0,
        24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'hE28C82,
        24'hC387, 24'hC3BC, 24'hC3A9, 24'hC3A2, 24'hC3A4, 24'hC3A0, 24'hC3A5, 24'hC3A7,
        24'hC3AA, 24'hC3AB, 24'hC3A8, 24'hC3AF, 24'hC3AE, 24'hC3AC, 24'hC384, 24'hC385,
        24'hC389, 24'hC3A6, 24'hC386, 24'hC3B4, 24'hC3B6, 24'hC3B2, 24'hC3BB, 24'hC3B9,
        24'hC3BF, 24'hC396, 24'hC39C, 24'hC2A2, 24'hC2A3, 24'hC2A5, 24'hE282A7, 24'hC692,
        24'hC3A1, 24'hC3AD, 24'hC3B3, 24'hC3BA, 24'hC3B1, 24'hC391, 24'hC2AA, 24'hC2BA,
        24'hC2BF, 24'hE28C90, 24'hC2AC, 24'hC2BD, 24'hC2BC, 24'hC2A1, 24'hC2AB, 24'hC2BB,
        24'hE29691, 24'hE29692, 24'hE29693, 24'hE29482, 24'hE294A4, 24'hE295A1,
        24'hE295A2, 24'hE29596, 24'hE29595, 24'hE295A3, 24'hE29591, 24'hE29597,
        24'hE2959D, 24'hE2959C, 24'hE2959B, 24'hE29490,
        24'hE29494, 24'hE294B4, 24'hE294AC, 24'hE2949C, 24'hE29480, 24'hE294BC,
        24'hE2959E, 24'hE2959F, 24'hE2959A, 24'hE29594, 24'hE295A9, 24'hE295A6,
        24'hE295A0, 24'hE29590, 24'hE295AC, 24'hE295A7,
        24'hE295A8, 24'hE295A4, 24'hE295A5, 24'hE29599, 24'hE29598, 24'hE29592,
        24'hE29593, 24'hE295AB, 24'hE295AA, 24'hE29498, 24'hE2948C, 24'hE29688,
        24'hE29684, 24'hE2968C, 24'hE29690, 24'hE29680,
        24'hCEB1, 24'hC39F, 24'hCE93, 24'hCF80, 24'hCEA3, 24'hCF83, 24'hC2B5, 24'hCF84,
        24'hCEA6, 24'hCE98, 24'hCEA9, 24'hCEB4, 24'hE2889E, 24'hCF86, 24'hCEB5,
        24'hE288A9,
        24'hE289A1, 24'hC2B1, 24'hE289A5, 24'hE289A4, 24'hE28CA0, 24'hE28CA1, 24'hC3B7,
        24'hE28988, 24'hC2B0, 24'hE28899, 24'hC2B7, 24'hE2889A, 24'hE281BF, 24'hC2B2,
        24'hE296A0, 24'hC2A0
    };

    // Look up a completed multi-byte key; lowest code wins, zero on miss.
    function automatic logic [ByteW-1:0] mb_lookup(input key_t key);
        logic [ByteW-1:0] code;
        code = '0;
        for (int k = 255; k >= 1; k--) begin
            if (MB_KEYS[k] != '0 && MB_KEYS[k] == key) begin
                code = ByteW'(k);
            end
        end
        return code;
    endfunction

endpackage

// ===== rtl/core/utf8_to_cp437_converter_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_to_cp437_converter_top
// Converts a UTF-8 byte stream into code page 437 bytes.
// ---------------------------------------------------------------------------
// Channel | Direction | tdata               | tlast
// s_      | in        | [7:0] in_byte       | end_of_file
// m_      | out       | [7:0] cp437_code    | (none)
//
// One word per cycle: the decoder state and the table match sit between
// the sequence registers and the output register, so every accepted word
// finishes in the cycle it is accepted; a code appears on m_ the next cycle.
// Reset (aresetn low, synchronous) clears the sequence state and m_tvalid.
// s_tready is high whenever the output register is empty or being drained,
// so a stalled m_ side holds one code and stalls the input only then.
`include "utf8_to_cp437_converter_top_macros.svh"

module utf8_to_cp437_converter_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_file
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] cp437_code
);

    logic [15:0] coll_reg, coll_next;     // earlier bytes of the sequence
    logic [1:0]  left_reg, left_next;     // bytes still expected
    logic [1:0]  len_reg,  len_next;      // 2 or 3; 0 marks a 4-byte sequence
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;

    logic        accept;
    logic [23:0] key;
    logic [1:0]  cur_len;
    logic        done;
    logic [7:0]  code;
    logic [7:0]  b;

    assign b        = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        coll_next    = coll_reg;
        left_next    = left_reg;
        len_next     = len_reg;
        cur_len      = len_reg;
        done         = 1'b0;
        key          = {coll_reg, b};
        code         = '0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (accept) begin
            if (left_reg == 2'd0) begin
                // Decode a lead byte.
                coll_next = {8'h00, b};
                if ((b & 8'hE0) == 8'hC0) begin
                    len_next  = 2'd2;
                    left_next = 2'd1;
                end else if ((b & 8'hF0) == 8'hE0) begin
                    len_next  = 2'd3;
                    left_next = 2'd2;
                end else if ((b & 8'hF8) == 8'hF0) begin
                    len_next  = 2'd0;
                    left_next = 2'd3;
                end else begin
                    // Single byte: only tab, LF, CR and printable ASCII pass.
                    done = 1'b1;
                    if (b == 8'h09 || b == 8'h0A || b == 8'h0D ||
                        (b >= 8'h20 && b <= 8'h7E)) begin
                        code = b;
                    end
                end
            end else begin
                coll_next = {coll_reg[7:0], b};
                left_next = left_reg - 2'd1;
                if (left_reg == 2'd1) begin
                    done = 1'b1;
                    // Four-byte sequences never match.
                    if (cur_len == 2'd2) begin
                        code = u2c437_pkg::mb_lookup({8'h00, key[15:0]});
                    end else if (cur_len == 2'd3) begin
                        code = u2c437_pkg::mb_lookup(key);
                    end
                end
            end
            if (done || s_tlast) begin
                coll_next = '0;
                left_next = '0;
                len_next  = '0;
            end
            if (code != 8'h00) begin
                m_valid_next = 1'b1;
                m_data_next  = code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coll_reg    <= '0;
            left_reg    <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            coll_reg    <= coll_next;
            left_reg    <= left_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `U2C_ASSERT_IMPL(a_no_zero_code, aclk, aresetn, m_tvalid |-> m_tdata != 8'h00,
        "zero code emitted")
    `U2C_ASSERT_IMPL(a_len_state, aclk, aresetn,
        (left_reg == 2'd0) |-> (len_reg == 2'd0 && coll_reg == 16'h0000),
        "idle state not cleared")
    `U2C_ASSERT_IMPL(a_hold_out, aclk, aresetn,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
        "stalled code changed")
    `U2C_ASSERT_RST(a_reset_clears, aclk, !aresetn |=> (!m_tvalid && left_reg == 2'd0),
        "reset did not clear state")

endmodule

// ===== tb/sv/tb_utf8_to_cp437_converter_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_utf8_to_cp437_converter_top
// Stream test of the UTF-8 to CP437 converter. A behavioral decoder predicts
// the CP437 code for each completed sequence; a scoreboard compares every output
// word in order. Directed sequences come first, then random well-formed
// UTF-8 text mixed with noise, under random input gaps and output stalls.
// ---------------------------------------------------------------------------

// Behavioral decoder and queue of expected CP437 codes.
class cp437_scoreboard;
    logic [23:0] seq_bytes;
    logic [1:0]  remaining;
    logic [1:0]  seq_len;
    bit          four_byte;
    logic [7:0]  pending_codes[$];
    int          errors;
    logic [23:0] keys[256];

    function new();
        keys = u2c437_pkg::MB_KEYS;
        seq_bytes = '0; remaining = '0; seq_len = '0; four_byte = 1'b0; errors = 0;
    endfunction

    function logic [7:0] lookup_code();
        logic [7:0] b;
        if (four_byte) return 8'h00;
        if (seq_len == 2'd1) begin
            b = seq_bytes[7:0];
            if (b == 8'h09 || b == 8'h0A || b == 8'h0D || (b >= 8'h20 && b <= 8'h7E))
                return b;
            return 8'h00;
        end
        for (int k = 1; k < 256; k++) begin
            if (keys[k] != 24'h0 && keys[k] == seq_bytes) return 8'(k);
        end
        return 8'h00;
    endfunction

    // Advance the decoder with one accepted byte.
    function void note_byte(logic [7:0] b, bit eof);
        logic [7:0] code;
        if (remaining == 2'd0) begin
            four_byte = 1'b0;
            seq_bytes = {16'h0, b};
            if (b[7:5] == 3'b110) begin
                seq_len = 2'd2; remaining = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                seq_len = 2'd3; remaining = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                seq_len = 2'd0; four_byte = 1'b1; remaining = 2'd3;
            end else begin
                seq_len = 2'd1; remaining = 2'd0;
            end
        end else begin
            seq_bytes = {seq_bytes[15:0], b};
            remaining = remaining - 2'd1;
        end
        if (remaining == 2'd0) begin
            code = lookup_code();
            seq_bytes = '0; seq_len = '0; four_byte = 1'b0;
            if (code != 8'h00) pending_codes.push_back(code);
        end else if (eof) begin
            seq_bytes = '0; remaining = '0; seq_len = '0; four_byte = 1'b0;
        end
    endfunction

    function void check_code(logic [7:0] actual);
        logic [7:0] want;
        if (pending_codes.size() == 0) begin
            $error("unexpected word: cp437_code=%02h", actual);
            errors++;
            return;
        end
        want = pending_codes.pop_front();
        if (want !== actual) begin
            $error("cp437_code mismatch: expected %02h actual %02h", want, actual);
            errors++;
        end
    endfunction
endclass

module tb_utf8_to_cp437_converter_top;
    localparam int WatchdogLimit = 20000;
    localparam int ItemTarget    = 900;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    cp437_scoreboard sb;
    bit  hold_output;   // long receiver stall requested by the stimulus
    int  idle_cycles;
    int  sent_bytes;

    utf8_to_cp437_converter_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [7:0] in_byte
        .s_tlast (s_tlast),   // end_of_file
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // [7:0] cp437_code
    );

    always begin
        aclk = 1'b0; #2;
        aclk = 1'b1; #2;
    end

    initial begin
        sb = new();
        hold_output = 1'b0;
    end

    // Sample both channels at the rising edge; feed the scoreboard and
    // count cycles in which no word moves on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_code(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Receiver: its own stall pattern, plus the long hold when asked.
    initial begin
        int phase;
        m_tready = 1'b0;
        phase = 0;
        forever begin
            @(negedge aclk);
            phase++;
            if (hold_output) m_tready <= 1'b0;
            else if (phase % 400 < 100) m_tready <= 1'b1;     // no stalls here
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Offer one word and hold it until it is accepted.
    task automatic send_byte(input logic [7:0] b, input bit eof);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_bytes++;
        @(negedge aclk);
    endtask

    task automatic gap(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic send_key(input logic [23:0] key, input bit eof);
        if (key[23:16] != 8'h00) send_byte(key[23:16], 1'b0);
        send_byte(key[15:8], 1'b0);
        send_byte(key[7:0], eof);
    endtask

    // Random well-formed text with some noise and broken sequences.
    task automatic send_random_sequence();
        int pick;
        int code;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)), $urandom_range(0, 15) == 0);
        end else if (pick < 70) begin
            code = $urandom_range(1, 255);
            if (sb.keys[code] != 0) send_key(sb.keys[code], $urandom_range(0, 15) == 0);
            else send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 78) begin
            // four-byte sequence
            send_byte({5'b11110, 3'($urandom)}, 1'b0);
            repeat (3) send_byte(8'($urandom), 1'b0);
        end else if (pick < 86) begin
            // truncated by end of file
            send_byte({3'b111, 5'($urandom)} & 8'hEF, 1'b0);
            send_byte(8'($urandom), 1'b1);
        end else begin
            send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        int burst;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        idle_cycles = 0;
        sent_bytes  = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: single-byte edges, controls, stray bytes.
        send_byte(8'h00, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h1F, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Two- and three-byte entries at the table ends.
        send_key(24'hC2A0, 1'b0);          // code 255
        send_key(24'hE298BA, 1'b0);        // code 1
        send_key(24'hE28C82, 1'b1);        // completes on end of file
        // Four-byte sequence is swallowed whole.
        send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b0);
        // Zero byte inside a sequence.
        send_byte(8'hC3, 1'b0); send_byte(8'h00, 1'b0);
        // Partial sequence cut by end of file, then a fresh byte.
        send_byte(8'hE2, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF7, 1'b0); send_byte(8'h80, 1'b1);
        send_byte(8'h42, 1'b0);

        // Sender pause: drain every expected code.
        gap(1);
        while (sb.pending_codes.size() != 0) @(negedge aclk);

        // Long receiver hold while the sender keeps offering words.
        fork
            begin
                hold_output = 1'b1;
                repeat (60) @(negedge aclk);
                hold_output = 1'b0;
            end
            repeat (20) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
        join

        // Random part in bursts with random gaps.
        while (sent_bytes < ItemTarget) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                if (sent_bytes < ItemTarget) send_random_sequence();
            end
            if ($urandom_range(0, 2) == 0) gap($urandom_range(1, 8));
        end
        gap(1);

        while (sb.pending_codes.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== utf8_to_cp437_converter_top.f =====
+incdir+rtl/core
rtl/core/u2c437_pkg.sv
rtl/core/utf8_to_cp437_converter_top.sv
tb/sv/tb_utf8_to_cp437_converter_top.sv
